FILE: hdl/csl_pkg.sv
package csl_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_NUM, M_CHR, M_CHRESC,
    M_STR, M_STRESC, M_NAME, M_SYM
  } mode_t;

  // back-end sequencing: take a byte, check keywords, flush a name, return, end
  typedef enum logic [2:0] {
    P_TAKE, P_KEY, P_FLUSH, P_REDO, P_END
  } phase_t;

  localparam logic [2:0] K_END = 3'd0;
  localparam logic [2:0] K_KEY = 3'd1;
  localparam logic [2:0] K_INT = 3'd2;
  localparam logic [2:0] K_IDC = 3'd3;
  localparam logic [2:0] K_SYM = 3'd4;
  localparam logic [2:0] K_STR = 3'd5;
  localparam logic [2:0] K_ERR = 3'd6;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_BAD  = 2'd1;
  localparam logic [1:0] E_OPEN = 2'd2;
  localparam logic [1:0] E_LONG = 2'd3;

  localparam logic [5:0] SYM_SLASH = 6'd8;
  localparam int NKEY = 15;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // request from front to back: one input item
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } req_t;

  // symbol reached by appending b to symbol cur, 0 when none
  function automatic logic [5:0] sym_extend(input logic [5:0] cur, input logic [7:0] b);
    logic [5:0] r;
    r = '0;
    unique case (cur)
      6'd0: begin
        unique case (b)
          "+": r = 6'd10; "-": r = 6'd11; ".": r = 6'd4; "~": r = 6'd5;
          "!": r = 6'd6; "*": r = 6'd7; "/": r = 6'd8; "%": r = 6'd9;
          "<": r = 6'd14; ">": r = 6'd16; "=": r = 6'd25; "&": r = 6'd20;
          "^": r = 6'd21; "|": r = 6'd22; ",": r = 6'd36; "(": r = 6'd37;
          ")": r = 6'd38; "{": r = 6'd39; "}": r = 6'd40; "[": r = 6'd41;
          "]": r = 6'd42; "?": r = 6'd43; ":": r = 6'd44; ";": r = 6'd45;
          default: r = '0;
        endcase
      end
      6'd10: r = (b == "+") ? 6'd1 : (b == "=") ? 6'd26 : 6'd0;
      6'd11: r = (b == "-") ? 6'd2 : (b == ">") ? 6'd3 : (b == "=") ? 6'd27 : 6'd0;
      6'd6:  r = (b == "=") ? 6'd19 : 6'd0;
      6'd7:  r = (b == "=") ? 6'd28 : 6'd0;
      6'd8:  r = (b == "=") ? 6'd29 : 6'd0;
      6'd9:  r = (b == "=") ? 6'd30 : 6'd0;
      6'd14: r = (b == "<") ? 6'd12 : (b == "=") ? 6'd15 : 6'd0;
      6'd16: r = (b == ">") ? 6'd13 : (b == "=") ? 6'd17 : 6'd0;
      6'd25: r = (b == "=") ? 6'd18 : 6'd0;
      6'd20: r = (b == "&") ? 6'd23 : (b == "=") ? 6'd33 : 6'd0;
      6'd21: r = (b == "=") ? 6'd34 : 6'd0;
      6'd22: r = (b == "|") ? 6'd24 : (b == "=") ? 6'd35 : 6'd0;
      6'd12: r = (b == "=") ? 6'd31 : 6'd0;
      6'd13: r = (b == "=") ? 6'd32 : 6'd0;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [71:0] key_text(input logic [3:0] k);
    logic [71:0] t;
    unique case (k)
      4'd0: t = "int";      4'd1: t = "print";  4'd2: t = "puts";
      4'd3: t = "return";   4'd4: t = "if";     4'd5: t = "break";
      4'd6: t = "continue"; 4'd7: t = "for";    4'd8: t = "while";
      4'd9: t = "void";     4'd10: t = "char";  4'd11: t = "signed";
      4'd12: t = "unsigned"; 4'd13: t = "long"; 4'd14: t = "const";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] key_len(input logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0, 4'd7: l = 4'd3;
      4'd2, 4'd9, 4'd10, 4'd13: l = 4'd4;
      4'd1, 4'd5, 4'd8, 4'd14: l = 4'd5;
      4'd3, 4'd11: l = 4'd6;
      4'd6, 4'd12: l = 4'd8;
      4'd4: l = 4'd2;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    return (b == "n") ? 8'd10 : (b == "t") ? 8'd9 : b;
  endfunction

endpackage

FILE: hdl/csl_front.sv
module csl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  csl_pkg::req_t   s_req,
  output logic            q_valid,
  input  logic            q_ready,
  output csl_pkg::req_t   q_req
);
  import csl_pkg::*;

  // two-entry request queue
  req_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign s_tready = count != 2'd2;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = count != 2'd0;
  assign pop      = q_valid && q_ready;
  assign q_req    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= s_req;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_nopush: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full queue");
  a_nopop: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule

FILE: hdl/csl_back.sv
module csl_back #(
  parameter int MAX_NAME = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  csl_pkg::req_t     q_req,
  output logic              m_tvalid,
  input  logic              m_tready,
  output csl_pkg::result_t  m_res
);
  import csl_pkg::*;

  localparam int LW = $clog2(MAX_NAME + 1);
  localparam int AW = $clog2(MAX_NAME);

  mode_t       mode, mode_next;
  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [LW-1:0] nlen, nlen_next;
  logic        novf, novf_next;
  logic [5:0]  sym, sym_next;
  logic [3:0]  kidx, kidx_next;
  logic        kmiss, kmiss_next;
  logic [LW-1:0] fidx, fidx_next;
  logic        eoi_pend, eoi_pend_next;

  logic [7:0]  nbuf [MAX_NAME];
  logic        nb_we;
  logic [AW-1:0] nb_wa, nb_ra;
  logic [7:0]  nb_rd;
  logic [71:0] ktext;
  logic        kmatch;

  logic        ovalid, ovalid_next;
  result_t     ores, ores_next;
  logic        emit;
  result_t     eres;
  logic        out_free;
  logic [7:0]  b;
  logic        take;

  assign b = q_req.byte_in;
  assign out_free = !ovalid || m_tready;
  assign m_tvalid = ovalid;
  assign m_res = ores;

  // buffer read data registered so it is ready the next cycle
  always_ff @(posedge clk) begin
    if (nb_we) nbuf[nb_wa] <= b;
    nb_rd <= nbuf[nb_ra];
  end

  always_comb begin
    logic [31:0] t32;
    logic [5:0]  s;
    t32 = '0;
    s = '0;
    mode_next = mode; phase_next = phase; acc_next = acc; nlen_next = nlen;
    novf_next = novf; sym_next = sym; kidx_next = kidx; kmiss_next = kmiss;
    fidx_next = fidx; eoi_pend_next = eoi_pend;
    emit = 1'b0; eres = '0; take = 1'b0; nb_we = 1'b0;
    nb_wa = nlen[AW-1:0]; nb_ra = '0;
    // keyword text moved up so its first character sits in the top byte
    ktext = key_text(kidx) << {4'd9 - key_len(kidx), 3'b000};
    kmatch = 1'b0;

    unique case (phase)
      P_TAKE: begin
        if (q_valid && out_free) begin
          if (q_req.end_of_input) begin
            unique case (mode)
              M_SLASH: begin emit = 1'b1; eres = '{K_SYM, 64'(SYM_SLASH), E_NONE, 1'b1}; end
              M_NUM: begin
                emit = 1'b1;
                eres = '{K_INT, {{32{acc[31]}}, acc[31:0]}, E_NONE, 1'b1};
              end
              M_CHR, M_CHRESC, M_STR, M_STRESC: begin
                emit = 1'b1; eres = '{K_ERR, 64'd0, E_OPEN, 1'b1};
              end
              M_SYM: begin emit = 1'b1; eres = '{K_SYM, 64'(sym), E_NONE, 1'b1}; end
              default: ;
            endcase
            if (mode == M_NAME) begin
              eoi_pend_next = 1'b1;
              kidx_next = '0; kmiss_next = 1'b0;
              nb_ra = '0;
              phase_next = P_KEY;
            end else begin
              phase_next = P_END;
            end
          end else begin
            take = 1'b1;
            unique case (mode)
              M_SLASH: begin
                if (b == "*") mode_next = M_BLOCK;
                else if (b == "/") mode_next = M_LINE;
                else begin mode_next = M_SYM; sym_next = SYM_SLASH; take = 1'b0; end
              end
              M_LINE: if (b == 8'd10) mode_next = M_IDLE;
              M_BLOCK: if (b == "*") mode_next = M_BSTAR;
              M_BSTAR: begin
                if (b == "/") mode_next = M_IDLE;
                else if (b != "*") mode_next = M_BLOCK;
              end
              M_NUM: begin
                if (is_digit(b)) begin
                  t32 = (acc[31:0] << 3) + (acc[31:0] << 1) + 32'(b - "0");
                  acc_next = {32'd0, t32};
                end else begin
                  emit = 1'b1;
                  eres = '{K_INT, {{32{acc[31]}}, acc[31:0]}, E_NONE, 1'b1};
                  mode_next = M_IDLE; acc_next = '0; take = 1'b0;
                end
              end
              M_CHR: begin
                if (b == "'") begin
                  emit = 1'b1; eres = '{K_INT, acc, E_NONE, 1'b1};
                  mode_next = M_IDLE; acc_next = '0;
                end else if (b == "\\") mode_next = M_CHRESC;
                else acc_next = {acc[55:0], b};
              end
              M_CHRESC: begin acc_next = {acc[55:0], unescape(b)}; mode_next = M_CHR; end
              M_STR: begin
                if (b == "\"") begin
                  emit = 1'b1; eres = '{K_STR, 64'd0, E_NONE, 1'b1}; mode_next = M_IDLE;
                end else if (b == "\\") mode_next = M_STRESC;
                else begin emit = 1'b1; eres = '{K_STR, 64'(b), E_NONE, 1'b0}; end
              end
              M_STRESC: begin
                emit = 1'b1; eres = '{K_STR, 64'(unescape(b)), E_NONE, 1'b0};
                mode_next = M_STR;
              end
              M_NAME: begin
                if (is_alpha(b) || is_digit(b)) begin
                  if (nlen < LW'(MAX_NAME)) begin
                    nb_we = 1'b1; nlen_next = nlen + 1'b1;
                  end else novf_next = 1'b1;
                end else begin
                  take = 1'b0; kidx_next = '0; kmiss_next = 1'b0;
                  nb_ra = '0; phase_next = P_KEY;
                end
              end
              M_SYM: begin
                s = sym_extend(sym, b);
                if (s != '0) sym_next = s;
                else begin
                  emit = 1'b1; eres = '{K_SYM, 64'(sym), E_NONE, 1'b1};
                  mode_next = M_IDLE; sym_next = '0; take = 1'b0;
                end
              end
              default: begin
                mode_next = M_IDLE;
                s = sym_extend('0, b);
                if (b == 8'd13 || b == 8'd10 || b == 8'd9 || b == 8'd11 || b == " "
                    || b == 8'd0) ;
                else if (b == "/") mode_next = M_SLASH;
                else if (is_digit(b)) begin mode_next = M_NUM; acc_next = 64'(b - "0"); end
                else if (b == "'") begin mode_next = M_CHR; acc_next = '0; end
                else if (b == "\"") mode_next = M_STR;
                else if (is_alpha(b)) begin
                  mode_next = M_NAME; nb_wa = '0; nb_we = 1'b1;
                  nlen_next = LW'(1); novf_next = 1'b0;
                end else if (s != '0) begin mode_next = M_SYM; sym_next = s; end
                else begin emit = 1'b1; eres = '{K_ERR, 64'(b), E_BAD, 1'b1}; end
              end
            endcase
          end
        end
      end
      // keyword check: one keyword at a time, one character per cycle over the buffer, held while the output is busy
      P_KEY: begin
        if (novf) begin
          if (out_free) begin
            emit = 1'b1; eres = '{K_ERR, 64'd0, E_LONG, 1'b1};
            phase_next = P_REDO;
          end
        end else begin
          if (nb_rd != ktext[8*(4'd8 - fidx[3:0]) +: 8] && fidx < LW'(key_len(kidx)))
            kmiss_next = 1'b1;
          // fidx walks positions; kidx walks keywords
          if (LW'(key_len(kidx)) != nlen) begin
            kidx_next = kidx + 1'b1; kmiss_next = 1'b0; fidx_next = '0; nb_ra = '0;
          end else if (fidx + 1'b1 < nlen) begin
            fidx_next = fidx + 1'b1; nb_ra = AW'(fidx + 1'b1);
          end else begin
            kmatch = !kmiss && !(nb_rd != ktext[8*(4'd8 - fidx[3:0]) +: 8]);
            if (kmatch) begin
              if (out_free) begin
                emit = 1'b1; eres = '{K_KEY, 64'(kidx), E_NONE, 1'b1};
                phase_next = P_REDO;
              end else begin
                kmiss_next = kmiss; fidx_next = fidx; nb_ra = AW'(fidx);
              end
            end else begin
              kidx_next = kidx + 1'b1; kmiss_next = 1'b0; fidx_next = '0; nb_ra = '0;
            end
          end
          if (phase_next == P_KEY && kidx_next == 4'(NKEY)) begin
            phase_next = P_FLUSH; fidx_next = '0; nb_ra = '0;
          end
        end
      end
      P_FLUSH: begin
        nb_ra = AW'(fidx);
        if (out_free) begin
          emit = 1'b1;
          eres = '{K_IDC, 64'(nb_rd), E_NONE, fidx + 1'b1 == nlen};
          fidx_next = fidx + 1'b1;
          nb_ra = AW'(fidx + 1'b1);
          if (fidx + 1'b1 == nlen) phase_next = P_REDO;
        end
      end
      P_REDO: begin
        // name done: return to idle, then either replay byte or finish eoi
        mode_next = M_IDLE; nlen_next = '0; novf_next = 1'b0; fidx_next = '0;
        kidx_next = '0;
        phase_next = eoi_pend ? P_END : P_TAKE;
      end
      P_END: begin
        if (out_free) begin
          emit = 1'b1; eres = '{K_END, 64'd0, E_NONE, 1'b1};
          take = 1'b1;
          mode_next = M_IDLE; acc_next = '0; nlen_next = '0; novf_next = 1'b0;
          sym_next = '0; eoi_pend_next = 1'b0; phase_next = P_TAKE;
        end
      end
      default: phase_next = P_TAKE;
    endcase

    if (kidx == 4'(NKEY)) ktext = '0;
    ovalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : ovalid);
    ores_next = emit ? eres : ores;
  end

  assign q_ready = take;

  always_ff @(posedge clk) begin
    ores <= ores_next;
    if (rst) begin
      mode <= M_IDLE; phase <= P_TAKE; acc <= '0; nlen <= '0; novf <= 1'b0;
      sym <= '0; kidx <= '0; kmiss <= 1'b0; fidx <= '0; eoi_pend <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      mode <= mode_next; phase <= phase_next; acc <= acc_next; nlen <= nlen_next;
      novf <= novf_next; sym <= sym_next; kidx <= kidx_next; kmiss <= kmiss_next;
      fidx <= fidx_next; eoi_pend <= eoi_pend_next; ovalid <= ovalid_next;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free) else $error("result overwritten");
  a_len: assert property (@(posedge clk) disable iff (rst)
    nlen <= LW'(MAX_NAME)) else $error("name length out of range");
  a_take: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> q_valid) else $error("take without request");
endmodule

FILE: hdl/c_subset_lexer_unit.sv
// a result is registered: valid the cycle after the back end emits it
// throughput: 1 byte per cycle while the output is free; a byte that ends a number,
//   name or symbol is replayed; a name is checked against each keyword, then its
//   characters are flushed if none matches, and the back end returns to idle;
//   end of input flushes the pending token, then an end result
// rst is synchronous, active high; clears mode, queue and output register
module c_subset_lexer_unit #(
  parameter int MAX_NAME = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // byte_in
  input  logic        s_tuser,  // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // kind[2:0], value[66:3], error_code[68:67], zeros
  output logic        m_tlast   // last
);
  import csl_pkg::*;

  req_t    s_req, q_req;
  logic    q_valid, q_ready;
  result_t res;

  assign s_req = '{s_tdata, s_tuser};

  csl_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_req,
    .q_valid, .q_ready, .q_req
  );

  csl_back #(.MAX_NAME(MAX_NAME)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req,
    .m_tvalid, .m_tready, .m_res(res)
  );

  assign m_tdata = {3'd0, res.error_code, res.value, res.kind};
  assign m_tlast = res.last;
endmodule
